// File: rtl/dea_pkg.sv
// Shared types and constants for the decimal exponent alignment block.
// No dependencies; every other file imports this package.
package dea_pkg;

  // Coefficient and scale widths
  localparam int COEF_W   = 96;
  localparam int LOW_W    = 64;
  localparam int HIGH_W   = 32;
  localparam int SCALE_W  = 5;

  // Division by ten runs MSB first over 16-bit chunks
  localparam int CHUNK_W   = 16;
  localparam int N_CHUNKS  = COEF_W / CHUNK_W;
  localparam int CHUNK_CW  = 3;
  localparam int REM_W     = 4;
  localparam int CUR_W     = REM_W + CHUNK_W;
  // q = (cur * RECIP) >> RECIP_SH, exact for cur below 2^22
  localparam int RECIP_W   = 20;
  localparam int RECIP_SH  = 23;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam logic [REM_W-1:0]   REM_HALF = 4'd5;

  typedef logic [COEF_W-1:0]   coef_t;
  typedef logic [SCALE_W-1:0]  scale_t;
  typedef logic [REM_W-1:0]    rem_t;

  typedef struct packed {
    logic [LOW_W-1:0]  coef_a_low;
    logic [HIGH_W-1:0] coef_a_high;
    scale_t            scale_a;
    logic [LOW_W-1:0]  coef_b_low;
    logic [HIGH_W-1:0] coef_b_high;
    scale_t            scale_b;
  } in_t;

  typedef struct packed {
    logic [LOW_W-1:0]  aligned_a_low;
    logic [HIGH_W-1:0] aligned_a_high;
    logic [LOW_W-1:0]  aligned_b_low;
    logic [HIGH_W-1:0] aligned_b_high;
    scale_t            common_scale;
  } out_t;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL10  = 2'd0,
    OP_DIVCH  = 2'd1,
    OP_ROUND  = 2'd2
  } op_t;

  // Unit request from the sequencer
  typedef struct packed {
    op_t   op;
    coef_t opnd;
    rem_t  rem;
    logic  sticky;
  } unit_req_t;

  // Unit response to the sequencer
  typedef struct packed {
    coef_t res;
    logic  fits;
    rem_t  rem;
    logic  sticky;
  } unit_rsp_t;

endpackage

// File: rtl/decimal_exponent_align.sv
// From accept to strobe the sequencer runs m multiply-by-ten steps, then d divisions, where
// diff = |scale_a - scale_b|, m = multiply-by-ten steps, d = diff - m divisions.
// Each multiply step is one S_MUL pass, and one more S_MUL pass ends the multiply phase;
// each divide runs over the six 16-bit chunks and then one rounding step, all through
// the one shared unit. busy stays high until the strobe cycle ends, so a new item
// is accepted only after the strobe.
// Reset (synchronous, rst_n low) returns to idle; the receiver cannot stall.
module decimal_exponent_align import dea_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_ROUND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  coef_t               a_r, a_nxt;
  coef_t               b_r, b_nxt;
  logic                big_a_r, big_a_nxt;
  scale_t              diff_r, diff_nxt;
  scale_t              scale_r, scale_nxt;
  logic                sticky_r, sticky_nxt;
  rem_t                rem_r, rem_nxt;
  logic [CHUNK_CW-1:0] chunk_r, chunk_nxt;

  unit_req_t req;
  unit_rsp_t rsp;
  coef_t     small_w, big_w;
  logic      accept;

  assign small_w = big_a_r ? b_r : a_r;
  assign big_w   = big_a_r ? a_r : b_r;
  assign accept  = start && !busy;

  // Drive the shared unit from the current state
  always_comb begin
    req.opnd   = big_w;
    req.rem    = rem_r;
    req.sticky = sticky_r;
    case (state_r)
      S_MUL: begin
        req.op   = OP_MUL10;
        req.opnd = small_w;
      end
      S_DIV:   req.op = OP_DIVCH;
      default: req.op = OP_ROUND;
    endcase
  end

  dea_unit u_unit (
    .req (req),
    .rsp (rsp)
  );

  // Sequencer: multiply phase, then divide-and-round steps
  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    big_a_nxt  = big_a_r;
    diff_nxt   = diff_r;
    scale_nxt  = scale_r;
    sticky_nxt = sticky_r;
    rem_nxt    = rem_r;
    chunk_nxt  = chunk_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt      = {in_item.coef_a_high, in_item.coef_a_low};
          b_nxt      = {in_item.coef_b_high, in_item.coef_b_low};
          big_a_nxt  = in_item.scale_a > in_item.scale_b;
          sticky_nxt = 1'b0;
          rem_nxt    = '0;
          chunk_nxt  = '0;
          if (in_item.scale_a > in_item.scale_b) begin
            scale_nxt = in_item.scale_b;
            diff_nxt  = in_item.scale_a - in_item.scale_b;
          end else begin
            scale_nxt = in_item.scale_a;
            diff_nxt  = in_item.scale_b - in_item.scale_a;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (diff_r == '0) begin
          state_nxt = S_DONE;
        end else if (rsp.fits) begin
          if (big_a_r) b_nxt = rsp.res;
          else         a_nxt = rsp.res;
          scale_nxt = scale_r + 1'b1;
          diff_nxt  = diff_r - 1'b1;
        end else begin
          rem_nxt   = '0;
          chunk_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (big_a_r) a_nxt = rsp.res;
        else         b_nxt = rsp.res;
        rem_nxt = rsp.rem;
        if (chunk_r == CHUNK_CW'(N_CHUNKS - 1)) begin
          state_nxt = S_ROUND;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_ROUND: begin
        if (big_a_r) a_nxt = rsp.res;
        else         b_nxt = rsp.res;
        sticky_nxt = rsp.sticky;
        rem_nxt    = rsp.rem;
        chunk_nxt  = '0;
        diff_nxt   = diff_r - 1'b1;
        state_nxt  = (diff_r == SCALE_W'(1)) ? S_DONE : S_DIV;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state under reset, payload registers run free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    big_a_r  <= big_a_nxt;
    diff_r   <= diff_nxt;
    scale_r  <= scale_nxt;
    sticky_r <= sticky_nxt;
    rem_r    <= rem_nxt;
    chunk_r  <= chunk_nxt;
  end

  // Present the item from the working registers in the done cycle
  assign busy                    = (state_r != S_IDLE);
  assign out_strobe              = (state_r == S_DONE);
  assign out_item.aligned_a_low  = a_r[LOW_W-1:0];
  assign out_item.aligned_a_high = a_r[COEF_W-1:LOW_W];
  assign out_item.aligned_b_low  = b_r[LOW_W-1:0];
  assign out_item.aligned_b_high = b_r[COEF_W-1:LOW_W];
  assign out_item.common_scale   = scale_r;

endmodule

// File: rtl/dea_unit.sv
// Shared arithmetic unit: multiply by ten, one 16-bit chunk of a divide by
// ten, or the half-even rounding increment. Depends on dea_pkg.
module dea_unit import dea_pkg::*; (
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [COEF_W+3:0]         prod10;
  logic [CUR_W-1:0]          cur;
  logic [CUR_W+RECIP_W-1:0]  recip_prod;
  logic [CHUNK_W-1:0]        q;
  logic [CUR_W-1:0]          q_times10;
  logic [CUR_W-1:0]          r_full;
  logic                      inc;

  // Times ten as 8x + 2x, four guard bits catch overflow
  assign prod10 = {1'b0, req.opnd, 3'b000} + {3'b000, req.opnd, 1'b0};

  // Chunk divide: remainder in front of the top chunk
  assign cur        = {req.rem, req.opnd[COEF_W-1 -: CHUNK_W]};
  assign recip_prod = {{RECIP_W{1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP};
  assign q          = recip_prod[RECIP_SH +: CHUNK_W];
  assign q_times10  = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
  assign r_full     = cur - q_times10;

  // Round up above half, or at half when odd or sticky
  assign inc = (req.rem > REM_HALF) ||
               ((req.rem == REM_HALF) && (req.opnd[0] || req.sticky));

  // Select the result of the requested operation
  always_comb begin
    rsp.res    = req.opnd;
    rsp.fits   = 1'b0;
    rsp.rem    = req.rem;
    rsp.sticky = req.sticky;
    case (req.op)
      OP_MUL10: begin
        rsp.res  = prod10[COEF_W-1:0];
        rsp.fits = (prod10[COEF_W+3:COEF_W] == 4'b0000);
      end
      OP_DIVCH: begin
        rsp.res = {req.opnd[COEF_W-CHUNK_W-1:0], q};
        rsp.rem = r_full[REM_W-1:0];
      end
      OP_ROUND: begin
        rsp.res    = req.opnd + {{(COEF_W-1){1'b0}}, inc};
        rsp.sticky = req.sticky || (req.rem != '0);
        rsp.rem    = '0;
      end
      default: begin
        rsp.res = req.opnd;
      end
    endcase
  end

endmodule

// File: rtl/dea_checker.sv
// Port-level checks for decimal_exponent_align, bound to the top level.
// Depends on dea_pkg.
module dea_checker import dea_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_item,
  input logic out_strobe,
  input out_t out_item
);

  // Accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // Strobe lasts one cycle and frees the block
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("strobe longer than one cycle or block still busy");

  // Result only while an item is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("strobe while idle");

  // Equal scales pass straight through S_MUL to the S_DONE strobe, keeping their scale
  a_equal_scale: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.scale_a == in_item.scale_b) |=> ##1
      out_strobe && (out_item.common_scale == $past(in_item.scale_a, 2)))
    else $error("equal-scale item not passed through");

endmodule

bind decimal_exponent_align dea_checker u_dea_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
